/* rtl/iuwf_pkg.sv */
// ----------------------------------------------------------------------------
// iuwf_pkg: shared definitions for the inverse-uncertainty weighted filter
// Constants, register indices and the control bundle of the shared divider.
// ----------------------------------------------------------------------------
package iuwf_pkg;

    // Default ring depth.
    localparam int DEF_MAX_POINTS = 16;

    // Field widths.
    localparam int OFF_W  = 32;
    localparam int UNC_W  = 32;
    localparam int PIU_W  = 5;
    localparam int RF_W   = 8;
    // A weight floor(2^40 / u) needs 41 bits.
    localparam int WGT_W  = 41;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_FACTOR = 2'd1;

    localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;
    localparam logic [RF_W-1:0]  RF_RESET  = 8'd4;

    // Request kinds.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Divider step counter width (enough for every numerator width in range).
    localparam int DIV_STEP_W = 8;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_ctl;

endpackage

/* rtl/iuwf_div.sv */
// ----------------------------------------------------------------------------
// iuwf_div: shared restoring divider, one quotient bit per cycle
// Takes a left-aligned numerator and runs the requested number of steps.
// ----------------------------------------------------------------------------
module iuwf_div #(
    parameter int NW = 80,
    parameter int DW = 46,
    parameter int QW = 41
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iuwf_pkg::t_div_ctl   i_ctl,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic [QW-1:0]        o_quo
);

    logic [NW-1:0]                   r_num;
    logic [DW-1:0]                   r_rem;
    logic [DW-1:0]                   r_den;
    logic [QW-1:0]                   r_quo;
    logic [iuwf_pkg::DIV_STEP_W-1:0] r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [DW:0]                     rem2;
    logic                            fits;

    assign rem2 = {r_rem, r_num[NW-1]};
    assign fits = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == iuwf_pkg::DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= fits ? DW'(rem2 - {1'b0, r_den}) : rem2[DW-1:0];
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/inverse_uncertainty_weighted_filter_core.sv */
// ----------------------------------------------------------------------------
// inverse_uncertainty_weighted_filter_core: weighted frequency-offset filter
// Keeps a ring of offset estimates and returns their inverse-uncertainty
// weighted mean and the combined uncertainty after every request.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+-----------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata offset, unc;
//           |           |                              | tuser req_type, valid
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata offset, unc,
//           |           |                              | count; tuser est_valid
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | index, data
//
// One item is worked on at a time. A clear request empties the ring and returns
// a zero result. An add first reads each entry of the ring to find the best
// valid uncertainty, then reads each entry again; per kept entry it runs a
// 41-step weight division and the states M1 to M4 on the shared 32x32
// multiplier. Then come a full-width division, the square root and a small
// division by the count; both divisions run on the one serial divider and
// the root is worked out bit by bit in the core. A rejected or skipped entry
// is only read and evaluated in the second pass.
// Reset is synchronous and active low and clears the valid flags at once,
// so no sweep over the store is needed. A finished result waits in the
// output register; the core takes the next item while it waits.
//
module inverse_uncertainty_weighted_filter_core #(
    parameter int MAX_POINTS = iuwf_pkg::DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] new_offset, [63:32] new_uncertainty
    input  logic [1:0]  s_axis_tuser,  // [0] req_type, [1] new_valid
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [31:0] est_offset, [63:32] est_uncertainty,
                                       // [68:64] used_count, [71:69] zero
    output logic        m_axis_tuser,  // [0] est_valid
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [iuwf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [iuwf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    // Signed weighted sum: each term is below 2^72, summed over the ring.
    localparam int SW   = 72 + CW;
    localparam int WSW  = iuwf_pkg::WGT_W + CW;
    localparam int SQW  = 64 + CW;
    localparam int RW   = (SQW + 1) / 2;
    localparam int SQP  = 2 * RW;
    localparam int OW   = iuwf_pkg::OFF_W;
    localparam int UW   = iuwf_pkg::UNC_W;
    localparam int WW   = iuwf_pkg::WGT_W;

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_SCAN_RD = 17'b00000000000000010,
        S_SCAN_EV = 17'b00000000000000100,
        S_LIM     = 17'b00000000000001000,
        S_C_RD    = 17'b00000000000010000,
        S_C_EV    = 17'b00000000000100000,
        S_C_DIV   = 17'b00000000001000000,
        S_M1      = 17'b00000000010000000,
        S_M2      = 17'b00000000100000000,
        S_M3      = 17'b00000001000000000,
        S_M4      = 17'b00000010000000000,
        S_FINAL   = 17'b00000100000000000,
        S_F_DIV   = 17'b00001000000000000,
        S_SQRT    = 17'b00010000000000000,
        S_SQ_END  = 17'b00100000000000000,
        S_U_DIV   = 17'b01000000000000000,
        S_FIN     = 17'b10000000000000000
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------
    logic [iuwf_pkg::PIU_W-1:0] r_piu;
    logic [iuwf_pkg::RF_W-1:0]  r_rf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= iuwf_pkg::PIU_RESET;
            r_rf  <= iuwf_pkg::RF_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                iuwf_pkg::CFG_POINTS_IN_USE: r_piu <= i_cfg_data[iuwf_pkg::PIU_W-1:0];
                iuwf_pkg::CFG_REJECT_FACTOR: r_rf  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective ring size: zero counts as one, and it never exceeds the store.
    logic [CW-1:0] n_eff;
    always_comb begin
        if (r_piu == '0) begin
            n_eff = CW'(1);
        end else if (int'(r_piu) > MAX_POINTS) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = CW'(r_piu);
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state;
    logic [CW-1:0]         r_n;
    logic [IW-1:0]         r_widx;
    logic [IW-1:0]         r_idx;
    logic [MAX_POINTS-1:0] r_vld;
    logic [UW:0]           r_best;
    logic [UW+7:0]         r_limit;
    logic [WW-1:0]         r_w;
    logic [63:0]           r_prod;
    logic signed [SW:0]    r_acc;
    logic [WSW-1:0]        r_wsum;
    logic [SQW-1:0]        r_sq;
    logic [CW-1:0]         r_cnt;
    logic [SQP-1:0]        r_sqsh;
    logic [RW:0]           r_srem;
    logic [RW-1:0]         r_rt;
    logic [iuwf_pkg::DIV_STEP_W-1:0] r_sc;
    logic [OW-1:0]         r_res_off;
    logic [UW-1:0]         r_res_unc;
    logic                  r_div_start;
    logic [iuwf_pkg::DIV_STEP_W-1:0] r_div_steps;
    logic [SW-1:0]         r_div_num;
    logic [WSW-1:0]        r_div_den;
    logic                  r_out_valid;
    logic [71:0]           r_out_data;
    logic                  r_out_user;

    // ------------------------------------------------------------------
    // Entry store: {uncertainty, offset}, one write and one read port.
    // The valid flags live in flip-flops so reset and clear act at once.
    // ------------------------------------------------------------------
    logic [63:0] mem [MAX_POINTS];
    logic [63:0] r_rdata;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic        mem_re;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_axis_tdata;
        end
        if (mem_re) begin
            r_rdata <= mem[r_idx];
        end
    end

    logic [OW-1:0] rd_off;
    logic [UW-1:0] rd_unc;
    logic          rd_neg;
    logic [OW-1:0] rd_mag;

    assign rd_off = r_rdata[OW-1:0];
    assign rd_unc = r_rdata[63:OW];
    assign rd_neg = rd_off[OW-1];
    // Magnitude of the offset; the most negative value maps onto 2^31.
    assign rd_mag = rd_neg ? (OW'(0) - rd_off) : rd_off;

    // ------------------------------------------------------------------
    // Input handshake and write index
    // ------------------------------------------------------------------
    logic          in_acc;
    logic [IW-1:0] widx_eff;
    logic [CW-1:0] widx_next;
    logic          idx_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    // A ring that shrank under the write index sends the write to entry 0.
    assign widx_eff      = (CW'(r_widx) >= n_eff) ? '0 : r_widx;
    assign widx_next     = CW'(widx_eff) + CW'(1);
    assign idx_last      = (CW'(r_idx) + CW'(1)) == r_n;
    assign mem_we        = in_acc && (s_axis_tuser[0] == iuwf_pkg::REQ_ADD);
    assign mem_waddr     = widx_eff;
    assign mem_re        = (r_state == S_SCAN_RD) || (r_state == S_C_RD);

    // ------------------------------------------------------------------
    // Shared multiplier, registered output
    // ------------------------------------------------------------------
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    always_comb begin
        mul_a = rd_mag;
        mul_b = r_w[31:0];
        case (r_state)
            S_M1:    begin mul_a = rd_unc; mul_b = rd_unc; end
            S_M3:    mul_b = 32'(r_w[WW-1:32]);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    iuwf_pkg::t_div_ctl div_ctl;
    logic               div_done;
    logic [WW-1:0]      div_quo;

    assign div_ctl.start = r_div_start;
    assign div_ctl.steps = r_div_steps;

    iuwf_div #(
        .NW (SW),
        .DW (WSW),
        .QW (WW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [SW:0]   p_lo_ext;
    logic [SW:0]   p_hi_ext;
    logic          acc_neg;
    logic [SW-1:0] acc_mag;
    logic [RW+2:0] sq_rem2;
    logic [RW+2:0] sq_trial;
    logic          sq_fit;
    logic          out_free;

    assign p_lo_ext = (SW+1)'(r_prod);
    // The upper weight bits times the magnitude fill up to 41 bits.
    assign p_hi_ext = (SW+1)'({r_prod[OW+WW-33:0], 32'b0});
    assign acc_neg  = r_acc[SW];
    assign acc_mag  = acc_neg ? SW'(-r_acc) : SW'(r_acc);
    assign sq_rem2  = {r_srem, r_sqsh[SQP-1 -: 2]};
    assign sq_trial = {1'b0, r_rt, 2'b01};
    assign sq_fit   = sq_rem2 >= sq_trial;
    assign out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= CW'(1);
            r_widx      <= '0;
            r_idx       <= '0;
            r_vld       <= '0;
            r_cnt       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_n   <= n_eff;
                        r_idx <= '0;
                        r_cnt <= '0;
                        if (s_axis_tuser[0] == iuwf_pkg::REQ_CLEAR) begin
                            r_vld     <= '0;
                            r_widx    <= '0;
                            r_res_off <= '0;
                            r_res_unc <= '0;
                            r_state   <= S_FIN;
                        end else begin
                            r_vld[widx_eff] <= s_axis_tuser[1];
                            r_widx  <= (widx_next >= n_eff) ? '0 : IW'(widx_next);
                            r_best  <= '1;
                            r_acc   <= '0;
                            r_wsum  <= '0;
                            r_sq    <= '0;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end

                S_SCAN_RD: r_state <= S_SCAN_EV;

                S_SCAN_EV: begin
                    if (r_vld[r_idx] && ({1'b0, rd_unc} < r_best)) begin
                        r_best <= {1'b0, rd_unc};
                    end
                    if (idx_last) begin
                        r_state <= S_LIM;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end

                S_LIM: begin
                    r_limit <= r_best[UW] ? '0 : r_rf * r_best[UW-1:0];
                    r_idx   <= '0;
                    r_state <= S_C_RD;
                end

                S_C_RD: r_state <= S_C_EV;

                S_C_EV: begin
                    if (r_vld[r_idx] && (rd_unc != '0)) begin
                        if ((UW+8)'(rd_unc) >= r_limit) begin
                            // Rejected entries stay out until overwritten.
                            r_vld[r_idx] <= 1'b0;
                            if (idx_last) begin
                                r_state <= S_FINAL;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_C_RD;
                            end
                        end else begin
                            r_cnt       <= r_cnt + 1'b1;
                            r_div_start <= 1'b1;
                            r_div_steps <= iuwf_pkg::DIV_STEP_W'(WW);
                            r_div_num   <= {1'b1, {(SW-1){1'b0}}};
                            r_div_den   <= WSW'(rd_unc);
                            r_state     <= S_C_DIV;
                        end
                    end else if (idx_last) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_C_RD;
                    end
                end

                S_C_DIV: begin
                    if (div_done) begin
                        r_w     <= div_quo;
                        r_state <= S_M1;
                    end
                end

                S_M1: r_state <= S_M2;

                S_M2: begin
                    r_sq    <= r_sq + SQW'(r_prod);
                    r_wsum  <= r_wsum + WSW'(r_w);
                    r_state <= S_M3;
                end

                S_M3: begin
                    r_acc   <= rd_neg ? r_acc - $signed(p_lo_ext) : r_acc + $signed(p_lo_ext);
                    r_state <= S_M4;
                end

                S_M4: begin
                    r_acc <= rd_neg ? r_acc - $signed(p_hi_ext) : r_acc + $signed(p_hi_ext);
                    if (idx_last) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_C_RD;
                    end
                end

                S_FINAL: begin
                    if (r_cnt == '0) begin
                        r_res_off <= '0;
                        r_res_unc <= '0;
                        r_state   <= S_FIN;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_steps <= iuwf_pkg::DIV_STEP_W'(SW);
                        r_div_num   <= acc_mag;
                        r_div_den   <= r_wsum;
                        r_state     <= S_F_DIV;
                    end
                end

                S_F_DIV: begin
                    if (div_done) begin
                        r_res_off <= acc_neg ? (OW'(0) - div_quo[OW-1:0]) : div_quo[OW-1:0];
                        r_sqsh    <= SQP'(r_sq);
                        r_srem    <= '0;
                        r_rt      <= '0;
                        r_sc      <= iuwf_pkg::DIV_STEP_W'(RW);
                        r_state   <= S_SQRT;
                    end
                end

                // Two bits of the sum of squares per cycle, one root bit out.
                S_SQRT: begin
                    r_sqsh <= {r_sqsh[SQP-3:0], 2'b00};
                    r_srem <= sq_fit ? (RW+1)'(sq_rem2 - sq_trial) : sq_rem2[RW:0];
                    r_rt   <= {r_rt[RW-2:0], sq_fit};
                    r_sc   <= r_sc - 1'b1;
                    if (r_sc == iuwf_pkg::DIV_STEP_W'(1)) begin
                        r_state <= S_SQ_END;
                    end
                end

                S_SQ_END: begin
                    r_div_start <= 1'b1;
                    r_div_steps <= iuwf_pkg::DIV_STEP_W'(RW);
                    r_div_num   <= {r_rt, {(SW-RW){1'b0}}};
                    r_div_den   <= WSW'(r_cnt);
                    r_state     <= S_U_DIV;
                end

                S_U_DIV: begin
                    if (div_done) begin
                        r_res_unc <= div_quo[UW-1:0];
                        r_state   <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload, loaded as the result leaves S_FIN.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_data <= {3'b000, 5'(r_cnt), r_res_unc, r_res_off};
            r_out_user <= (r_cnt != '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef NO_ASSERTIONS
    // The write index always points inside the ring it was computed for.
    a_widx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_widx) < r_n)
        else $error("write index outside ring");

    // No more entries are combined than the ring holds.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_n)
        else $error("combined count exceeds ring size");

    // A result appears only as the sequencer leaves its final state.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_FIN))
        else $error("result raised outside final state");
`endif

endmodule
